FILE: rtl/tbs_pkg.sv
// Shared types, codes and the byte-size lookup for the typed byte stack.
// No dependencies.
package tbs_pkg;

  localparam logic [31:0] TableReset = 32'h8844_2211;
  localparam int unsigned MaxBytes   = 8;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_PEEK = 2'd1,
    MODE_POP  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_WRITE = 6'b000100,
    S_RDENT = 6'b001000,
    S_RDREQ = 6'b010000,
    S_RDCAP = 6'b100000
  } state_e;

  // byte count of a type, fields above 8 saturate
  function automatic logic [3:0] tbs_size(logic [31:0] tbl, logic [2:0] t);
    logic [3:0] f;
    f = tbl[{t, 2'b00} +: 4];
    return (f > 4'(MaxBytes)) ? 4'(MaxBytes) : f;
  endfunction

endpackage

FILE: rtl/typed_byte_stack_unit.sv
// Top level of the typed byte stack: sequencer, byte store and entry tables.
// Depends on tbs_pkg.
//
// Channel   | Direction | Handshake                       | Payload
// ----------+-----------+---------------------------------+------------------------------------
// command   | in        | start_i, accepted when !busy_o  | mode_i, value_i, type_id_i,
//           |           |                                 | depth_index_i
// result    | out       | result_valid_o, one-cycle beat  | status_o, read_value_o, read_type_o
// config    | in        | cfg_valid_i / cfg_ready_o       | cfg_wdata_i (type size table)
//
// Sequence: a beat is taken in S_IDLE and decoded in S_CHECK. A push then writes one
// byte per cycle in S_WRITE; a peek or pop reads the entry tables in S_RDENT and then
// each byte through S_RDREQ (address) and S_RDCAP (registered read data). Refused
// items and mode 3 return to S_IDLE from S_CHECK. busy_o is low again in the cycle
// the result beat is shown, so the next command may be taken there.
// Reset: stack empty, size table back to its default. The stores need no clearing.
// The result beat cannot be stalled by the receiver.
module typed_byte_stack_unit
  import tbs_pkg::*;
#(
  parameter int unsigned DATA_BYTES  = 256,
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned TYPE_COUNT  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] value_i,
  input  logic [2:0]  type_id_i,
  input  logic [5:0]  depth_index_i,
  // result
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [63:0] read_value_o,
  output logic [2:0]  read_type_o,
  // config
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(DATA_BYTES);
  localparam int unsigned TopW  = $clog2(DATA_BYTES + 1);
  localparam int unsigned EntW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW  = (CntW > 6) ? CntW : 6;

  // control state
  state_e            state_q;
  logic [TopW-1:0]   top_q;
  logic [CntW-1:0]   count_q;
  logic [31:0]       table_q;
  logic              out_valid_q;

  // item registers
  logic [1:0]        mode_q;
  logic [63:0]       value_q;
  logic [2:0]        type_q;
  logic [5:0]        depth_q;
  logic [2:0]        k_q;
  logic [3:0]        n_q;
  logic [EntW-1:0]   idx_q;
  logic [TopW-1:0]   off_q;
  logic [2:0]        etype_q;
  logic [63:0]       acc_q;
  logic              inrange_q;

  // result registers
  status_e           status_q;
  logic [63:0]       rvalue_q;
  logic [2:0]        rtype_q;

  // memories
  logic [7:0]        byte_mem [DATA_BYTES];
  logic [TopW-1:0]   off_mem  [MAX_ENTRIES];
  logic [2:0]        type_mem [MAX_ENTRIES];
  logic [7:0]        byte_rdata_q;
  logic [TopW-1:0]   off_rdata_q;
  logic [2:0]        type_rdata_q;

  logic              byte_we;
  logic [AddrW-1:0]  byte_waddr;
  logic [AddrW-1:0]  byte_raddr;
  logic              ent_we;
  logic [EntW-1:0]   ent_raddr;

  // decode helpers
  logic [3:0]        sz_push;
  logic [3:0]        sz_ent;
  logic [TopW:0]     top_sum;
  logic [TopW:0]     rd_sum;
  logic [TopW:0]     wr_sum;
  logic              push_full;
  logic              peek_empty;
  logic              pop_empty;
  logic [CmpW-1:0]   depth_ext;
  logic [CmpW-1:0]   count_ext;
  logic [CmpW-1:0]   idx_calc;
  logic              last_byte;
  logic [63:0]       acc_next;

  always_comb begin
    sz_push    = tbs_size(table_q, type_q);
    sz_ent     = tbs_size(table_q, type_rdata_q);
    top_sum    = {1'b0, top_q} + (TopW+1)'(sz_push);
    push_full  = ({1'b0, type_q} >= 4'(TYPE_COUNT)) ||
                 (count_q >= CntW'(MAX_ENTRIES)) ||
                 (top_sum > (TopW+1)'(DATA_BYTES));
    depth_ext  = CmpW'(depth_q);
    count_ext  = CmpW'(count_q);
    peek_empty = depth_ext >= count_ext;
    pop_empty  = (count_q == '0);
    if (mode_q == MODE_PEEK) begin
      idx_calc = count_ext - CmpW'(1) - depth_ext;
    end else begin
      idx_calc = count_ext - CmpW'(1);
    end
    ent_raddr  = idx_calc[EntW-1:0];
    last_byte  = ({1'b0, k_q} == (n_q - 4'd1));
    wr_sum     = {1'b0, top_q} + (TopW+1)'(k_q);
    rd_sum     = {1'b0, off_q} + (TopW+1)'(k_q);
    byte_waddr = wr_sum[AddrW-1:0];
    byte_raddr = rd_sum[AddrW-1:0];
    byte_we    = (state_q == S_WRITE);
    ent_we     = ((state_q == S_CHECK) && (mode_q == MODE_PUSH) && !push_full &&
                  (sz_push == 4'd0)) ||
                 ((state_q == S_WRITE) && last_byte);
    // accumulator with the byte just read merged in; bytes past the store stay zero
    acc_next   = acc_q;
    if (inrange_q) begin
      acc_next[{k_q, 3'b000} +: 8] = byte_rdata_q;
    end
  end

  // byte store
  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= value_q[7:0];
    end
    byte_rdata_q <= byte_mem[byte_raddr];
  end

  // entry tables
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      off_mem[count_q[EntW-1:0]]  <= top_q;
      type_mem[count_q[EntW-1:0]] <= type_q;
    end
    off_rdata_q  <= off_mem[ent_raddr];
    type_rdata_q <= type_mem[ent_raddr];
  end

  // sequencer and stack pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      count_q     <= '0;
      table_q     <= TableReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        table_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          case (mode_q)
            MODE_PUSH: begin
              if (push_full) begin
                state_q     <= S_IDLE;
                out_valid_q <= 1'b1;
              end else if (sz_push == 4'd0) begin
                count_q     <= count_q + CntW'(1);
                state_q     <= S_IDLE;
                out_valid_q <= 1'b1;
              end else begin
                state_q <= S_WRITE;
              end
            end
            MODE_PEEK: begin
              if (peek_empty) begin
                state_q     <= S_IDLE;
                out_valid_q <= 1'b1;
              end else begin
                state_q <= S_RDENT;
              end
            end
            MODE_POP: begin
              if (pop_empty) begin
                state_q     <= S_IDLE;
                out_valid_q <= 1'b1;
              end else begin
                state_q <= S_RDENT;
              end
            end
            default: begin
              state_q     <= S_IDLE;
              out_valid_q <= 1'b1;
            end
          endcase
        end
        S_WRITE: begin
          if (last_byte) begin
            top_q       <= top_q + TopW'(n_q);
            count_q     <= count_q + CntW'(1);
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        S_RDENT: begin
          if (sz_ent == 4'd0) begin
            if (mode_q == MODE_POP) begin
              top_q   <= off_rdata_q;
              count_q <= CntW'(idx_q);
            end
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= S_RDREQ;
          end
        end
        S_RDREQ: begin
          state_q <= S_RDCAP;
        end
        S_RDCAP: begin
          if (last_byte) begin
            if (mode_q == MODE_POP) begin
              top_q   <= off_q;
              count_q <= CntW'(idx_q);
            end
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= S_RDREQ;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        mode_q  <= mode_i;
        value_q <= value_i;
        type_q  <= type_id_i;
        depth_q <= depth_index_i;
      end
      S_CHECK: begin
        k_q      <= '0;
        n_q      <= sz_push;
        idx_q    <= idx_calc[EntW-1:0];
        rvalue_q <= '0;
        rtype_q  <= '0;
        case (mode_q)
          MODE_PUSH: status_q <= push_full ? ST_FULL : ST_OK;
          MODE_PEEK: status_q <= peek_empty ? ST_EMPTY : ST_OK;
          MODE_POP:  status_q <= pop_empty ? ST_EMPTY : ST_OK;
          default:   status_q <= ST_OK;
        endcase
      end
      S_WRITE: begin
        value_q <= {8'h00, value_q[63:8]};
        k_q     <= k_q + 3'd1;
      end
      S_RDENT: begin
        off_q    <= off_rdata_q;
        etype_q  <= type_rdata_q;
        n_q      <= sz_ent;
        acc_q    <= '0;
        rtype_q  <= type_rdata_q;
      end
      S_RDREQ: begin
        inrange_q <= rd_sum < (TopW+1)'(DATA_BYTES);
      end
      S_RDCAP: begin
        if (last_byte) begin
          rvalue_q <= acc_next;
        end
        acc_q   <= acc_next;
        k_q     <= k_q + 3'd1;
        rtype_q <= etype_q;
      end
      default: begin
        k_q <= '0;
      end
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = out_valid_q;
  assign status_o       = status_q;
  assign read_value_o   = rvalue_q;
  assign read_type_o    = rtype_q;

`ifndef ASSERT_OFF
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TopW'(DATA_BYTES))
    else $error("byte top past the store");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count past the limit");

  a_empty_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (top_q == '0))
    else $error("empty stack holds bytes");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !result_valid_o))
    else $error("accepted beat did not start the sequencer");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy_o && $past(busy_o)))
    else $error("result beat without a finished item");
`endif

endmodule
